// ----- src/k_medoids_cluster_engine_macros.svh -----
// Assertion macros used by the k-medoids cluster engine datapath.
`ifndef K_MEDOIDS_CLUSTER_ENGINE_MACROS_SVH
`define K_MEDOIDS_CLUSTER_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
`define KMC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define KMC_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define KMC_ASSERT(label, clk, rst_n, prop, msg)
`define KMC_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

// ----- src/kmc_pkg.sv -----
// Types and constants of the k-medoids cluster engine.
`default_nettype none
package kmc_pkg;

    localparam int PT_W   = 8;
    localparam int NPT    = 256;
    localparam int CL_W   = 4;
    localparam int NCL    = 16;
    localparam int DIST_W = 16;
    localparam int COST_W = DIST_W + PT_W;
    localparam int CNT_W  = 9;
    localparam int K_W    = 5;
    localparam int LIM_W  = 10;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PASS_LIMIT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT   = 2'd2;

    localparam logic [K_W-1:0]   RST_CLUSTER_COUNT = 5'd1;
    localparam logic [LIM_W-1:0] RST_PASS_LIMIT    = 10'd200;
    localparam logic [CNT_W-1:0] RST_POINT_COUNT   = 9'd256;

    typedef enum logic [1:0] {
        FUNC_LOAD_DIST   = 2'd0,
        FUNC_LOAD_MEDOID = 2'd1,
        FUNC_RUN         = 2'd2,
        FUNC_READ        = 2'd3
    } kmc_func_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_BAD_ARG   = 2'd1,
        STAT_DUPLICATE = 2'd2,
        STAT_MISSING   = 2'd3
    } kmc_status_t;

    typedef enum logic [4:0] {
        S_IDLE, S_RD_OUT, S_INIT, S_PASS_BEGIN, S_A_PT, S_A_RD, S_A_CMP,
        S_U_CAND, S_U_QRD, S_U_QACC, S_U_CMP, S_U_PRD, S_U_PCHK, S_U_END,
        S_PASS_END, S_F_CLEAR, S_F_RD, S_F_ACC, S_F_RANK, S_F_DONE
    } kmc_state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_ITEM, OP_RD_OUT, OP_INIT, OP_PASS_BEGIN, OP_A_PT, OP_A_RD,
        OP_A_CMP, OP_U_CAND, OP_U_QRD, OP_U_QACC, OP_U_CMP, OP_U_PRD, OP_U_PCHK,
        OP_U_END, OP_PASS_END, OP_F_CLEAR, OP_F_RD, OP_F_ACC, OP_F_RANK, OP_F_DONE
    } kmc_op_t;

    typedef struct packed {
        kmc_op_t op;
    } kmc_cmd_t;

    typedef struct packed {
        logic pt_last;
        logic cl_last;
        logic qt_last;
        logic is_med;
        logic member;
        logic run_ok;
        logic lim_zero;
        logic moved;
        logic at_limit;
        logic first;
        logic skid_full;
    } kmc_stat_t;

    typedef struct packed {
        kmc_status_t       status;
        logic [CL_W-1:0]   prank;
        logic              pmed;
        logic [PT_W-1:0]   rmed;
        logic [CNT_W-1:0]  rsize;
        logic [LIM_W-1:0]  passes;
        logic              conv;
    } kmc_result_t;

endpackage
`default_nettype wire

// ----- src/kmc_ctrl.sv -----
// Sequencer of the k-medoids cluster engine.
`default_nettype none
module kmc_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    input  wire kmc_pkg::kmc_func_t item_func,
    input  wire kmc_pkg::kmc_stat_t stat,
    output logic                    s_tready,
    output kmc_pkg::kmc_cmd_t       cmd
);
    import kmc_pkg::*;

    kmc_state_t state_reg, state_next;
    logic fire;

    assign s_tready = (state_reg == S_IDLE) && !stat.skid_full;
    assign fire = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd.op = OP_NONE;
        case (state_reg)
            S_IDLE: begin
                if (fire) begin
                    cmd.op = OP_ITEM;
                    case (item_func)
                        FUNC_RUN:  state_next = stat.run_ok ? S_INIT : S_IDLE;
                        FUNC_READ: state_next = S_RD_OUT;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_RD_OUT: begin
                cmd.op = OP_RD_OUT;
                state_next = S_IDLE;
            end
            S_INIT: begin
                cmd.op = OP_INIT;
                if (stat.cl_last) begin
                    state_next = stat.lim_zero ? S_F_CLEAR : S_PASS_BEGIN;
                end
            end
            S_PASS_BEGIN: begin
                cmd.op = OP_PASS_BEGIN;
                state_next = S_A_PT;
            end
            S_A_PT: begin
                cmd.op = OP_A_PT;
                if (stat.is_med) begin
                    state_next = stat.pt_last ? S_U_CAND : S_A_PT;
                end else begin
                    state_next = S_A_RD;
                end
            end
            S_A_RD: begin
                cmd.op = OP_A_RD;
                state_next = S_A_CMP;
            end
            S_A_CMP: begin
                cmd.op = OP_A_CMP;
                if (stat.cl_last) begin
                    state_next = stat.pt_last ? S_U_CAND : S_A_PT;
                end else begin
                    state_next = S_A_RD;
                end
            end
            S_U_CAND: begin
                cmd.op = OP_U_CAND;
                state_next = S_U_QRD;
            end
            S_U_QRD: begin
                cmd.op = OP_U_QRD;
                state_next = S_U_QACC;
            end
            S_U_QACC: begin
                cmd.op = OP_U_QACC;
                state_next = stat.qt_last ? S_U_CMP : S_U_QRD;
            end
            S_U_CMP: begin
                cmd.op = OP_U_CMP;
                state_next = (!stat.first && stat.pt_last) ? S_U_END : S_U_PRD;
            end
            S_U_PRD: begin
                cmd.op = OP_U_PRD;
                state_next = S_U_PCHK;
            end
            S_U_PCHK: begin
                cmd.op = OP_U_PCHK;
                if (stat.member) begin
                    state_next = S_U_QRD;
                end else begin
                    state_next = stat.pt_last ? S_U_END : S_U_PRD;
                end
            end
            S_U_END: begin
                cmd.op = OP_U_END;
                state_next = stat.cl_last ? S_PASS_END : S_U_CAND;
            end
            S_PASS_END: begin
                cmd.op = OP_PASS_END;
                state_next = (!stat.moved || stat.at_limit) ? S_F_CLEAR : S_PASS_BEGIN;
            end
            S_F_CLEAR: begin
                cmd.op = OP_F_CLEAR;
                state_next = S_F_RD;
            end
            S_F_RD: begin
                cmd.op = OP_F_RD;
                state_next = S_F_ACC;
            end
            S_F_ACC: begin
                cmd.op = OP_F_ACC;
                state_next = stat.pt_last ? S_F_RANK : S_F_RD;
            end
            S_F_RANK: begin
                cmd.op = OP_F_RANK;
                state_next = stat.cl_last ? S_F_DONE : S_F_RANK;
            end
            S_F_DONE: begin
                cmd.op = OP_F_DONE;
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- src/kmc_datapath.sv -----
// Datapath of the k-medoids cluster engine: stores, counters, costs, result words.
`default_nettype none
`include "k_medoids_cluster_engine_macros.svh"
module kmc_datapath (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire kmc_pkg::kmc_cmd_t                cmd,
    input  wire kmc_pkg::kmc_func_t               item_func,
    input  wire logic [kmc_pkg::PT_W-1:0]         item_row,
    input  wire logic [kmc_pkg::PT_W-1:0]         item_col,
    input  wire logic [kmc_pkg::DIST_W-1:0]       item_dist,
    input  wire logic [kmc_pkg::CL_W-1:0]         item_slot,
    input  wire logic                             cfg_valid,
    input  wire logic [kmc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [kmc_pkg::LIM_W-1:0]        cfg_data,
    input  wire logic                             m_tready,
    output logic                                  m_tvalid,
    output kmc_pkg::kmc_result_t                  m_word,
    output kmc_pkg::kmc_stat_t                    stat
);
    import kmc_pkg::*;

    // configuration
    logic [K_W-1:0]   k_reg;
    logic [LIM_W-1:0] lim_reg;
    logic [CNT_W-1:0] n_reg;

    // loaded medoids and working state
    logic [PT_W-1:0]  medoid_reg [NCL];
    logic [PT_W-1:0]  medoid_next [NCL];
    logic [NCL-1:0]   loaded_reg, loaded_next;
    logic [PT_W-1:0]  cur_reg [NCL];
    logic [PT_W-1:0]  cur_next [NCL];
    logic [CL_W-1:0]  rank_reg [NCL];
    logic [CL_W-1:0]  rank_next [NCL];
    logic [CNT_W-1:0] size_reg [NCL];
    logic [CNT_W-1:0] size_next [NCL];

    logic [PT_W-1:0]   pt_reg, pt_next, qt_reg, qt_next, cand_reg, cand_next;
    logic [PT_W-1:0]   best_pt_reg, best_pt_next, q_row_reg, q_row_next;
    logic [CL_W-1:0]   cl_reg, cl_next, best_c_reg, best_c_next, q_slot_reg, q_slot_next;
    logic [DIST_W-1:0] best_d_reg, best_d_next;
    logic [COST_W-1:0] cost_reg, cost_next, best_cost_reg, best_cost_next;
    logic              first_reg, first_next, moved_reg, moved_next, conv_reg, conv_next;
    logic [LIM_W-1:0]  passes_reg, passes_next;
    logic [CNT_W-1:0]  run_n_reg, run_n_next;
    logic [K_W-1:0]    run_k_reg, run_k_next;

    // result words
    kmc_result_t out_reg, out_next, skid_reg, skid_next, res;
    logic        out_valid_reg, out_valid_next, skid_valid_reg, skid_valid_next;
    logic        emit, take;

    // memories
    logic [DIST_W-1:0] dist_mem [NPT*NPT];
    logic [DIST_W-1:0] dist_rd_reg;
    logic              dmem_we;
    logic [2*PT_W-1:0] dmem_waddr, dmem_raddr;
    logic [CL_W-1:0]   clus_mem [NPT];
    logic [CL_W-1:0]   clus_rd_reg;
    logic              cl_we;
    logic [PT_W-1:0]   cl_waddr, cl_raddr;
    logic [CL_W-1:0]   cl_wdata;

    // derived
    logic [PT_W-1:0]   cur_cl, pt_adv;
    logic              pt_last, cl_last, qt_last, pt_med, member, take_d;
    logic [CL_W-1:0]   pt_med_idx, nb_c;
    logic              dist_ok, med_bad, med_dup, k_bad, missing, range_bad, dup;
    kmc_status_t       med_status, run_status;
    logic [CNT_W-1:0]  size_cl;
    logic [K_W-1:0]    rank_cnt;
    logic              q_med_hit, q_pmed, q_pt_ok, q_rank_ok;
    logic [CL_W-1:0]   q_prank;
    logic [PT_W-1:0]   q_rmed;
    logic [CNT_W-1:0]  q_rsize;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg   <= RST_CLUSTER_COUNT;
            lim_reg <= RST_PASS_LIMIT;
            n_reg   <= RST_POINT_COUNT;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_CLUSTER_COUNT: k_reg   <= cfg_data[K_W-1:0];
                CFG_PASS_LIMIT:    lim_reg <= cfg_data;
                CFG_POINT_COUNT:   n_reg   <= cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (dmem_we) begin
            dist_mem[dmem_waddr] <= item_dist;
        end
        dist_rd_reg <= dist_mem[dmem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (cl_we) begin
            clus_mem[cl_waddr] <= cl_wdata;
        end
        clus_rd_reg <= clus_mem[cl_raddr];
    end

    assign cur_cl  = cur_reg[cl_reg];
    assign pt_last = ({1'b0, pt_reg} == n_reg - CNT_W'(1));
    assign qt_last = ({1'b0, qt_reg} == n_reg - CNT_W'(1));
    assign cl_last = ({1'b0, cl_reg} == k_reg - K_W'(1));
    assign pt_adv  = pt_last ? '0 : pt_reg + PT_W'(1);
    assign member  = (clus_rd_reg == cl_reg) && (pt_reg != cur_cl);
    assign take_d  = (cl_reg == '0) || (dist_rd_reg < best_d_reg);
    assign nb_c    = take_d ? cl_reg : best_c_reg;
    assign size_cl = size_reg[cl_reg];
    assign dist_ok = ({1'b0, item_row} < n_reg) && ({1'b0, item_col} < n_reg);
    assign med_bad = ({1'b0, item_slot} >= k_reg) || ({1'b0, item_col} >= n_reg);

    // parallel checks over the cluster slots
    always_comb begin
        pt_med = 1'b0;
        pt_med_idx = '0;
        med_dup = 1'b0;
        missing = 1'b0;
        range_bad = 1'b0;
        dup = 1'b0;
        rank_cnt = '0;
        q_med_hit = 1'b0;
        q_prank = '0;
        q_pmed = 1'b0;
        q_rmed = '0;
        q_rsize = '0;
        for (int c = 0; c < NCL; c++) begin
            if (K_W'(c) < k_reg) begin
                if (cur_reg[c] == pt_reg) begin
                    pt_med = 1'b1;
                    pt_med_idx = CL_W'(c);
                end
                if (CL_W'(c) != item_slot && loaded_reg[c] && medoid_reg[c] == item_col) begin
                    med_dup = 1'b1;
                end
                if (!loaded_reg[c]) begin
                    missing = 1'b1;
                end
                if ({1'b0, medoid_reg[c]} >= n_reg) begin
                    range_bad = 1'b1;
                end
                for (int d = c + 1; d < NCL; d++) begin
                    if (K_W'(d) < k_reg && medoid_reg[c] == medoid_reg[d]) begin
                        dup = 1'b1;
                    end
                end
                if (size_reg[c] > size_cl || (size_reg[c] == size_cl && CL_W'(c) < cl_reg)) begin
                    rank_cnt = rank_cnt + K_W'(1);
                end
            end
            if (K_W'(c) < run_k_reg) begin
                if (cur_reg[c] == q_row_reg) begin
                    q_med_hit = 1'b1;
                end
                if (CL_W'(c) == clus_rd_reg) begin
                    q_prank = rank_reg[c];
                    q_pmed = (cur_reg[c] == q_row_reg);
                end
                if (rank_reg[c] == q_slot_reg) begin
                    q_rmed = cur_reg[c];
                    q_rsize = size_reg[c];
                end
            end
        end
    end

    assign k_bad = (k_reg == '0) || (k_reg > K_W'(NCL)) || ({4'b0, k_reg} > n_reg)
                   || (n_reg == '0) || (n_reg > CNT_W'(NPT));
    assign run_status = k_bad ? STAT_BAD_ARG : missing ? STAT_MISSING :
                        range_bad ? STAT_BAD_ARG : dup ? STAT_DUPLICATE : STAT_OK;
    assign med_status = med_bad ? STAT_BAD_ARG : med_dup ? STAT_DUPLICATE : STAT_OK;
    assign q_pt_ok   = ({1'b0, q_row_reg} < run_n_reg) && (passes_reg != '0 || q_med_hit);
    assign q_rank_ok = ({1'b0, q_slot_reg} < run_k_reg);
    assign take = out_valid_reg && m_tready;

    always_comb begin
        medoid_next = medoid_reg;
        loaded_next = loaded_reg;
        cur_next = cur_reg;
        rank_next = rank_reg;
        size_next = size_reg;
        pt_next = pt_reg;
        qt_next = qt_reg;
        cand_next = cand_reg;
        best_pt_next = best_pt_reg;
        q_row_next = q_row_reg;
        cl_next = cl_reg;
        best_c_next = best_c_reg;
        q_slot_next = q_slot_reg;
        best_d_next = best_d_reg;
        cost_next = cost_reg;
        best_cost_next = best_cost_reg;
        first_next = first_reg;
        moved_next = moved_reg;
        conv_next = conv_reg;
        passes_next = passes_reg;
        run_n_next = run_n_reg;
        run_k_next = run_k_reg;
        dmem_we = 1'b0;
        dmem_waddr = {item_row, item_col};
        dmem_raddr = {pt_reg, cur_cl};
        cl_we = 1'b0;
        cl_waddr = pt_reg;
        cl_wdata = cl_reg;
        cl_raddr = pt_reg;
        emit = 1'b0;
        res = '0;
        res.passes = passes_reg;
        res.conv = conv_reg;
        case (cmd.op)
            OP_ITEM: begin
                case (item_func)
                    FUNC_LOAD_DIST: begin
                        emit = 1'b1;
                        if (dist_ok) begin
                            dmem_we = 1'b1;
                        end else begin
                            res.status = STAT_BAD_ARG;
                        end
                    end
                    FUNC_LOAD_MEDOID: begin
                        emit = 1'b1;
                        res.status = med_status;
                        if (med_status == STAT_OK) begin
                            medoid_next[item_slot] = item_col;
                            loaded_next[item_slot] = 1'b1;
                        end
                    end
                    FUNC_RUN: begin
                        if (run_status != STAT_OK) begin
                            emit = 1'b1;
                            res.status = run_status;
                        end else begin
                            cur_next = medoid_reg;
                            passes_next = '0;
                            conv_next = 1'b0;
                            cl_next = '0;
                        end
                    end
                    FUNC_READ: begin
                        cl_raddr = item_row;
                        q_row_next = item_row;
                        q_slot_next = item_slot;
                    end
                    default: ;
                endcase
            end
            OP_RD_OUT: begin
                emit = 1'b1;
                res.status = (q_pt_ok && q_rank_ok) ? STAT_OK : STAT_BAD_ARG;
                if (q_pt_ok) begin
                    res.prank = q_prank;
                    res.pmed = q_pmed;
                end
                if (q_rank_ok) begin
                    res.rmed = q_rmed;
                    res.rsize = q_rsize;
                end
            end
            OP_INIT: begin
                cl_we = 1'b1;
                cl_waddr = cur_cl;
                cl_wdata = cl_reg;
                cl_next = cl_last ? '0 : cl_reg + CL_W'(1);
            end
            OP_PASS_BEGIN: begin
                passes_next = passes_reg + LIM_W'(1);
                moved_next = 1'b0;
                pt_next = '0;
                cl_next = '0;
            end
            OP_A_PT: begin
                if (pt_med) begin
                    cl_we = 1'b1;
                    cl_wdata = pt_med_idx;
                    pt_next = pt_adv;
                end else begin
                    cl_next = '0;
                end
            end
            OP_A_CMP: begin
                if (take_d) begin
                    best_d_next = dist_rd_reg;
                    best_c_next = cl_reg;
                end
                if (cl_last) begin
                    cl_we = 1'b1;
                    cl_wdata = nb_c;
                    cl_next = '0;
                    pt_next = pt_adv;
                end else begin
                    cl_next = cl_reg + CL_W'(1);
                end
            end
            OP_U_CAND: begin
                cand_next = cur_cl;
                first_next = 1'b1;
                qt_next = '0;
                cost_next = '0;
                pt_next = '0;
            end
            OP_U_QRD: begin
                dmem_raddr = {cand_reg, qt_reg};
                cl_raddr = qt_reg;
            end
            OP_U_QACC: begin
                if (clus_rd_reg == cl_reg) begin
                    cost_next = cost_reg + COST_W'(dist_rd_reg);
                end
                qt_next = qt_last ? '0 : qt_reg + PT_W'(1);
            end
            OP_U_CMP: begin
                if (first_reg || cost_reg < best_cost_reg) begin
                    best_cost_next = cost_reg;
                    best_pt_next = cand_reg;
                end
                first_next = 1'b0;
                cost_next = '0;
                if (!first_reg) begin
                    pt_next = pt_adv;
                end
            end
            OP_U_PCHK: begin
                if (member) begin
                    cand_next = pt_reg;
                    qt_next = '0;
                end else begin
                    pt_next = pt_adv;
                end
            end
            OP_U_END: begin
                if (best_pt_reg != cur_cl) begin
                    cur_next[cl_reg] = best_pt_reg;
                    moved_next = 1'b1;
                end
                pt_next = '0;
                cl_next = cl_last ? '0 : cl_reg + CL_W'(1);
            end
            OP_PASS_END: begin
                conv_next = !moved_reg;
            end
            OP_F_CLEAR: begin
                for (int c = 0; c < NCL; c++) begin
                    size_next[c] = '0;
                end
                pt_next = '0;
                cl_next = '0;
            end
            OP_F_ACC: begin
                // before any pass only the starting medoids hold a cluster
                if (passes_reg != '0 || pt_med) begin
                    for (int c = 0; c < NCL; c++) begin
                        if (CL_W'(c) == clus_rd_reg) begin
                            size_next[c] = size_reg[c] + CNT_W'(1);
                        end
                    end
                end
                pt_next = pt_adv;
            end
            OP_F_RANK: begin
                rank_next[cl_reg] = rank_cnt[CL_W-1:0];
                cl_next = cl_last ? '0 : cl_reg + CL_W'(1);
            end
            OP_F_DONE: begin
                run_n_next = n_reg;
                run_k_next = k_reg;
                emit = 1'b1;
            end
            default: ;
        endcase
    end

    // output word and skid word
    always_comb begin
        out_next = out_reg;
        skid_next = skid_reg;
        out_valid_next = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (emit) begin
            if (!out_valid_reg || take) begin
                if (skid_valid_reg) begin
                    out_next = skid_reg;
                    skid_next = res;
                end else begin
                    out_next = res;
                    out_valid_next = 1'b1;
                end
            end else begin
                skid_next = res;
                skid_valid_next = 1'b1;
            end
        end else if (take) begin
            if (skid_valid_reg) begin
                out_next = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loaded_reg <= '0;
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
            passes_reg <= '0;
            conv_reg <= 1'b0;
            run_n_reg <= '0;
            run_k_reg <= '0;
            moved_reg <= 1'b0;
            first_reg <= 1'b0;
            pt_reg <= '0;
            qt_reg <= '0;
            cl_reg <= '0;
        end else begin
            loaded_reg <= loaded_next;
            out_valid_reg <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
            passes_reg <= passes_next;
            conv_reg <= conv_next;
            run_n_reg <= run_n_next;
            run_k_reg <= run_k_next;
            moved_reg <= moved_next;
            first_reg <= first_next;
            pt_reg <= pt_next;
            qt_reg <= qt_next;
            cl_reg <= cl_next;
        end
    end

    always_ff @(posedge aclk) begin
        medoid_reg <= medoid_next;
        cur_reg <= cur_next;
        rank_reg <= rank_next;
        size_reg <= size_next;
        cand_reg <= cand_next;
        best_pt_reg <= best_pt_next;
        q_row_reg <= q_row_next;
        best_c_reg <= best_c_next;
        q_slot_reg <= q_slot_next;
        best_d_reg <= best_d_next;
        cost_reg <= cost_next;
        best_cost_reg <= best_cost_next;
        out_reg <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_word = out_reg;

    assign stat.pt_last   = pt_last;
    assign stat.cl_last   = cl_last;
    assign stat.qt_last   = qt_last;
    assign stat.is_med    = pt_med;
    assign stat.member    = member;
    assign stat.run_ok    = (run_status == STAT_OK);
    assign stat.lim_zero  = (lim_reg == '0);
    assign stat.moved     = moved_reg;
    assign stat.at_limit  = (passes_reg == lim_reg);
    assign stat.first     = first_reg;
    assign stat.skid_full = skid_valid_reg;

    `KMC_ASSERT(a_skid_behind_out, aclk, aresetn, skid_valid_reg |-> out_valid_reg, "skid word without output word")
    `KMC_NEVER(a_no_overrun, aclk, aresetn, emit && skid_valid_reg && !take, "result word dropped")
    `KMC_ASSERT(a_pass_bound, aclk, aresetn, (cmd.op == OP_PASS_END) |-> (passes_reg != '0 && passes_reg <= lim_reg), "pass count out of bounds")

endmodule
`default_nettype wire

// ----- src/k_medoids_cluster_engine.sv -----
// Top level of the k-medoids cluster engine: stream ports, sequencer and datapath.
// Load words are handled at acceptance and read words add a read-out state; one word is in work at a time.
// A run word with k clusters, n points and P passes runs an init step, P passes of assignment and
// medoid update, and a final size and rank step; its length is set by the single distance read port.
// The input stalls while the output and skid words are both held by the receiver.
// Reset (aresetn low, synchronous) clears control state and loaded-medoid flags; stores hold garbage.
`default_nettype none
module k_medoids_cluster_engine (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // s_tdata: row_point[7:0], col_point[15:8], distance[31:16], cluster_slot[35:32]
    input  wire logic [39:0]                    s_tdata,
    // s_tuser: func[1:0]
    input  wire logic [1:0]                     s_tuser,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // m_tdata: point_rank[3:0], point_is_medoid[4], rank_medoid[12:5],
    //          rank_size[21:13], passes_done[31:22], converged[32]
    output logic [39:0]                         m_tdata,
    // m_tuser: status[1:0]
    output logic [1:0]                          m_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [kmc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [kmc_pkg::LIM_W-1:0]      cfg_data
);
    import kmc_pkg::*;

    kmc_cmd_t    cmd;
    kmc_stat_t   stat;
    kmc_result_t m_word;
    kmc_func_t   item_func;

    // configuration writes are always accepted
    assign cfg_ready = 1'b1;
    assign item_func = kmc_func_t'(s_tuser);

    kmc_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .item_func (item_func),
        .stat      (stat),
        .s_tready  (s_tready),
        .cmd       (cmd)
    );

    kmc_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .item_func (item_func),
        .item_row  (s_tdata[7:0]),
        .item_col  (s_tdata[15:8]),
        .item_dist (s_tdata[31:16]),
        .item_slot (s_tdata[35:32]),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_word    (m_word),
        .stat      (stat)
    );

    // pack the result word, first field in the low bits
    assign m_tdata = {7'b0, m_word.conv, m_word.passes, m_word.rsize, m_word.rmed,
                      m_word.pmed, m_word.prank};
    assign m_tuser = m_word.status;

endmodule
`default_nettype wire

// ----- verif/k_medoids_cluster_engine_test.sv -----
// Self-checking testbench of the k-medoids cluster engine: a scoreboard predicts every result word.
`timescale 1ns / 1ps
`default_nettype none

// Predicts the result word of each accepted input word and checks the result stream in order.
class cluster_scoreboard;
    logic [15:0] dist_mem [65536];
    bit [7:0]  seed_medoid [16];
    bit [15:0] seed_loaded;
    bit [3:0]  pt_cluster [256];
    bit        pt_member [256];
    bit [3:0]  cl_rank [16];
    bit [8:0]  cl_size [16];
    bit [7:0]  cl_medoid [16];
    bit [9:0]  pass_cnt;
    bit        conv_flag;
    int        last_n;
    int        last_k;
    bit [4:0]  reg_k;
    bit [9:0]  reg_limit;
    bit [8:0]  reg_n;
    kmc_pkg::kmc_result_t expected_q[$];
    int        errors;
    int        checked;
    int        runs_ok;
    int        reads_ok;

    function new();
        seed_loaded = '0;
        foreach (pt_cluster[p]) begin
            pt_cluster[p] = '0;
            pt_member[p]  = 1'b0;
        end
        foreach (cl_rank[c]) begin
            seed_medoid[c] = '0;
            cl_rank[c]     = '0;
            cl_size[c]     = '0;
            cl_medoid[c]   = '0;
        end
        pass_cnt  = '0;
        conv_flag = 1'b0;
        last_n    = 0;
        last_k    = 0;
        reg_k     = kmc_pkg::RST_CLUSTER_COUNT;
        reg_limit = kmc_pkg::RST_PASS_LIMIT;
        reg_n     = kmc_pkg::RST_POINT_COUNT;
        errors    = 0;
        checked   = 0;
        runs_ok   = 0;
        reads_ok  = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [9:0] val);
        if (idx == kmc_pkg::CFG_CLUSTER_COUNT) reg_k = val[4:0];
        else if (idx == kmc_pkg::CFG_PASS_LIMIT) reg_limit = val;
        else if (idx == kmc_pkg::CFG_POINT_COUNT) reg_n = val[8:0];
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // One full clustering run; state changes only when it succeeds.
    function kmc_pkg::kmc_status_t cluster_run();
        int k;
        int n;
        int cur [16];
        bit asg [256];
        bit is_med [256];
        int grp [256];
        int moved;
        int passes;
        int left;
        int best;
        int r;
        longint best_cost;
        longint cost;
        k = reg_k;
        n = reg_n;
        moved = 1;
        passes = 0;
        if (k == 0 || k > 16 || k > n || n == 0 || n > 256) return kmc_pkg::STAT_BAD_ARG;
        for (int c = 0; c < k; c++)
            if (!seed_loaded[c]) return kmc_pkg::STAT_MISSING;
        for (int c = 0; c < k; c++)
            if (seed_medoid[c] >= n) return kmc_pkg::STAT_BAD_ARG;
        for (int c = 0; c < k; c++)
            for (int d = c + 1; d < k; d++)
                if (seed_medoid[c] == seed_medoid[d]) return kmc_pkg::STAT_DUPLICATE;
        for (int p = 0; p < 256; p++) begin
            asg[p] = 1'b0;
            grp[p] = 0;
        end
        for (int c = 0; c < k; c++) begin
            cur[c] = seed_medoid[c];
            asg[cur[c]] = 1'b1;
            grp[cur[c]] = c;
        end
        left = reg_limit;
        while (left >= 1 && moved != 0) begin
            left--;
            passes++;
            moved = 0;
            for (int p = 0; p < 256; p++) is_med[p] = 1'b0;
            for (int c = 0; c < k; c++) is_med[cur[c]] = 1'b1;
            // nearest medoid, ties to the lower cluster
            for (int p = 0; p < n; p++) begin
                if (is_med[p]) continue;
                best = 0;
                for (int c = 1; c < k; c++)
                    if (dist_mem[p*256 + cur[c]] < dist_mem[p*256 + cur[best]]) best = c;
                grp[p] = best;
                asg[p] = 1'b1;
            end
            for (int c = 0; c < k; c++) grp[cur[c]] = c;
            // medoid update, current medoid wins cost ties
            for (int c = 0; c < k; c++) begin
                best = cur[c];
                best_cost = 0;
                for (int q = 0; q < n; q++)
                    if (asg[q] && grp[q] == c) best_cost += dist_mem[best*256 + q];
                for (int p = 0; p < n; p++) begin
                    if (!asg[p] || grp[p] != c || p == cur[c]) continue;
                    cost = 0;
                    for (int q = 0; q < n; q++)
                        if (asg[q] && grp[q] == c) cost += dist_mem[p*256 + q];
                    if (cost < best_cost) begin
                        best_cost = cost;
                        best = p;
                    end
                end
                if (best != cur[c]) begin
                    moved++;
                    cur[c] = best;
                end
            end
        end
        for (int c = 0; c < 16; c++) begin
            cl_size[c] = '0;
            cl_rank[c] = '0;
            cl_medoid[c] = '0;
        end
        for (int p = 0; p < 256; p++) begin
            pt_member[p]  = (p < n) && asg[p];
            pt_cluster[p] = pt_member[p] ? 4'(grp[p]) : 4'd0;
            if (pt_member[p]) cl_size[grp[p]]++;
        end
        for (int c = 0; c < k; c++) begin
            cl_medoid[c] = 8'(cur[c]);
            r = 0;
            for (int d = 0; d < k; d++)
                if (cl_size[d] > cl_size[c] || (cl_size[d] == cl_size[c] && d < c)) r++;
            cl_rank[c] = 4'(r);
        end
        pass_cnt  = 10'(passes);
        conv_flag = (moved == 0);
        last_n    = n;
        last_k    = k;
        runs_ok++;
        return kmc_pkg::STAT_OK;
    endfunction

    function void note_word(kmc_pkg::kmc_func_t fn, logic [7:0] row, logic [7:0] col,
                            logic [15:0] dval, logic [3:0] slot);
        kmc_pkg::kmc_result_t res;
        res = '0;
        res.status = kmc_pkg::STAT_OK;
        case (fn)
            kmc_pkg::FUNC_LOAD_DIST: begin
                if (row < reg_n && col < reg_n) dist_mem[row*256 + col] = dval;
                else res.status = kmc_pkg::STAT_BAD_ARG;
            end
            kmc_pkg::FUNC_LOAD_MEDOID: begin
                if (slot >= reg_k || col >= reg_n) begin
                    res.status = kmc_pkg::STAT_BAD_ARG;
                end else begin
                    for (int c = 0; c < reg_k && c < 16; c++)
                        if (c != slot && seed_loaded[c] && seed_medoid[c] == col)
                            res.status = kmc_pkg::STAT_DUPLICATE;
                    if (res.status == kmc_pkg::STAT_OK) begin
                        seed_medoid[slot] = col;
                        seed_loaded[slot] = 1'b1;
                    end
                end
            end
            kmc_pkg::FUNC_RUN: res.status = cluster_run();
            default: begin
                if (row < last_n && pt_member[row]) begin
                    res.prank = cl_rank[pt_cluster[row]];
                    res.pmed  = (cl_medoid[pt_cluster[row]] == row);
                end else begin
                    res.status = kmc_pkg::STAT_BAD_ARG;
                end
                if (slot < last_k) begin
                    for (int c = 0; c < last_k; c++)
                        if (cl_rank[c] == slot) begin
                            res.rmed  = cl_medoid[c];
                            res.rsize = cl_size[c];
                        end
                end else begin
                    res.status = kmc_pkg::STAT_BAD_ARG;
                end
                if (res.status == kmc_pkg::STAT_OK) reads_ok++;
            end
        endcase
        res.passes = pass_cnt;
        res.conv   = conv_flag;
        expected_q.insert(expected_q.size(), res);
    endfunction

    function void check_word(kmc_pkg::kmc_result_t got);
        kmc_pkg::kmc_result_t exp;
        if (expected_q.size() == 0) begin
            $display("%0t: unexpected result word %h", $time, got);
            errors++;
            return;
        end
        exp = expected_q.pop_front();
        checked++;
        if (got.status !== exp.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
            errors++;
        end
        if (got.prank !== exp.prank) begin
            $display("%0t: point_rank expected %0d actual %0d", $time, exp.prank, got.prank);
            errors++;
        end
        if (got.pmed !== exp.pmed) begin
            $display("%0t: point_is_medoid expected %0d actual %0d", $time, exp.pmed, got.pmed);
            errors++;
        end
        if (got.rmed !== exp.rmed) begin
            $display("%0t: rank_medoid expected %0d actual %0d", $time, exp.rmed, got.rmed);
            errors++;
        end
        if (got.rsize !== exp.rsize) begin
            $display("%0t: rank_size expected %0d actual %0d", $time, exp.rsize, got.rsize);
            errors++;
        end
        if (got.passes !== exp.passes) begin
            $display("%0t: passes_done expected %0d actual %0d", $time, exp.passes, got.passes);
            errors++;
        end
        if (got.conv !== exp.conv) begin
            $display("%0t: converged expected %0d actual %0d", $time, exp.conv, got.conv);
            errors++;
        end
    endfunction
endclass

module k_medoids_cluster_engine_test;
    import kmc_pkg::*;

    localparam int TIMEOUT_CYCLES = 4000000;

    logic        aclk;
    logic        aresetn;
    logic [39:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [9:0]  cfg_data;

    cluster_scoreboard sb;
    int  words_sent;
    int  results_seen;
    int  cycle_count;
    bit  quiet;
    bit  hold_done;
    int  perm [256];

    k_medoids_cluster_engine u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Monitor: note accepted input words first, then check result words.
    // Everything here runs before the edge's nonblocking updates, so it sees pre-edge values.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_word(kmc_func_t'(s_tuser), s_tdata[7:0], s_tdata[15:8],
                             s_tdata[31:16], s_tdata[35:32]);
            if (m_tvalid && m_tready) begin
                kmc_result_t got;
                got.status = kmc_status_t'(m_tuser);
                got.prank  = m_tdata[3:0];
                got.pmed   = m_tdata[4];
                got.rmed   = m_tdata[12:5];
                got.rsize  = m_tdata[21:13];
                got.passes = m_tdata[31:22];
                got.conv   = m_tdata[32];
                sb.check_word(got);
                results_seen++;
            end
        end
    end

    // Watchdog: end the run if the block hangs.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= TIMEOUT_CYCLES) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // Result side: random stall bursts, one long hold-off to back up the block, none at the end.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!hold_done && results_seen >= 300) begin
                m_tready = 1'b0;
                repeat (600) @(negedge aclk);
                hold_done = 1'b1;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge aclk);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // Present one word and hold it until accepted; valid stays high on return.
    task automatic send_word(kmc_func_t fn, logic [7:0] row, logic [7:0] col,
                             logic [15:0] dval, logic [3:0] slot);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge aclk);
        end
        s_tdata  = {4'b0, slot, dval, col, row};
        s_tuser  = fn;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        words_sent++;
    endtask

    // Drop valid and wait until every expected word is back and the block has settled.
    task automatic drain();
        s_tvalid = 1'b0;
        while (sb.pending() > 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [9:0] val);
        drain();
        cfg_index = idx;
        cfg_data  = val;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, val);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic read_word(int row, int slot);
        send_word(FUNC_READ, row[7:0], 8'($urandom), 16'($urandom), slot[3:0]);
    endtask

    // Full matrix load, k distinct seeds, one run, then a handful of reads.
    task automatic cluster_phase(int n, int k, int lim, int reads);
        int tmp;
        int j;
        bit seeded;
        bit narrow;
        write_reg(CFG_POINT_COUNT, 10'(n));
        write_reg(CFG_CLUSTER_COUNT, 10'(k));
        write_reg(CFG_PASS_LIMIT, 10'(lim));
        narrow = ($urandom_range(0, 1) == 0);
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
                send_word(FUNC_LOAD_DIST, 8'(r), 8'(c),
                          narrow ? 16'($urandom_range(0, 7)) : 16'($urandom), 4'($urandom));
        for (int p = 0; p < n; p++) perm[p] = p;
        for (int p = n - 1; p > 0; p--) begin
            j = $urandom_range(0, p);
            tmp = perm[p];
            perm[p] = perm[j];
            perm[j] = tmp;
        end
        // Stale seeds from earlier phases can reject a load; retry up to four times until all land.
        for (int attempt = 0; attempt < 4; attempt++) begin
            seeded = 1'b1;
            for (int s = 0; s < k; s++)
                send_word(FUNC_LOAD_MEDOID, 8'($urandom), 8'(perm[s]), 16'($urandom), 4'(s));
            for (int s = 0; s < k; s++)
                if (!sb.seed_loaded[s] || sb.seed_medoid[s] != perm[s]) seeded = 1'b0;
            if (seeded) break;
        end
        send_word(FUNC_RUN, 8'($urandom), 8'($urandom), 16'($urandom), 4'($urandom));
        for (int i = 0; i < reads; i++)
            read_word($urandom_range(0, n), $urandom_range(0, k));
    endtask

    initial begin
        int n;
        int k;
        int lim;
        sb = new();
        words_sent = 0;
        results_seen = 0;
        cycle_count = 0;
        quiet = 1'b0;
        hold_done = 1'b0;
        s_tdata = '0;
        s_tuser = FUNC_LOAD_DIST;
        s_tvalid = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_CLUSTER_COUNT;
        cfg_data = '0;
        aresetn = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed: a bad read before any run, missing and duplicate seeds, range errors.
        read_word(0, 0);
        send_word(FUNC_RUN, 8'h00, 8'h00, 16'h0000, 4'h0);
        send_word(FUNC_LOAD_DIST, 8'hFF, 8'hFF, 16'hFFFF, 4'hF);
        send_word(FUNC_LOAD_DIST, 8'h00, 8'h00, 16'h0000, 4'h0);
        send_word(FUNC_LOAD_MEDOID, 8'h00, 8'h05, 16'h0000, 4'h1);
        send_word(FUNC_LOAD_MEDOID, 8'h00, 8'hFF, 16'h0000, 4'h0);
        write_reg(CFG_POINT_COUNT, 2);
        write_reg(CFG_CLUSTER_COUNT, 2);
        send_word(FUNC_RUN, 8'h00, 8'h00, 16'h0000, 4'h0);
        send_word(FUNC_LOAD_MEDOID, 8'h00, 8'hFF, 16'h0000, 4'h1);
        send_word(FUNC_LOAD_MEDOID, 8'h00, 8'h01, 16'h0000, 4'h1);
        send_word(FUNC_RUN, 8'h00, 8'h00, 16'h0000, 4'h0);
        send_word(FUNC_LOAD_MEDOID, 8'h00, 8'h01, 16'h0000, 4'h0);
        send_word(FUNC_LOAD_MEDOID, 8'h00, 8'h00, 16'h0000, 4'h0);
        send_word(FUNC_LOAD_DIST, 8'h00, 8'h01, 16'h0003, 4'h0);
        send_word(FUNC_LOAD_DIST, 8'h01, 8'h00, 16'h0003, 4'h0);
        send_word(FUNC_LOAD_DIST, 8'h01, 8'h01, 16'h0000, 4'h0);
        send_word(FUNC_LOAD_DIST, 8'h02, 8'h01, 16'h0001, 4'h0);
        // zero pass limit: medoids only, no passes
        write_reg(CFG_PASS_LIMIT, 0);
        send_word(FUNC_RUN, 8'h00, 8'h00, 16'h0000, 4'h0);
        read_word(1, 1);
        read_word(2, 2);
        write_reg(CFG_PASS_LIMIT, 1023);
        send_word(FUNC_RUN, 8'h00, 8'h00, 16'h0000, 4'h0);
        read_word(0, 0);
        // k above n, k zero, k above the cluster maximum, n zero, n above the point maximum
        write_reg(CFG_CLUSTER_COUNT, 3);
        send_word(FUNC_RUN, 8'h00, 8'h00, 16'h0000, 4'h0);
        write_reg(CFG_CLUSTER_COUNT, 0);
        send_word(FUNC_RUN, 8'h00, 8'h00, 16'h0000, 4'h0);
        write_reg(CFG_CLUSTER_COUNT, 20);
        send_word(FUNC_LOAD_MEDOID, 8'h00, 8'h00, 16'h0000, 4'hF);
        send_word(FUNC_RUN, 8'h00, 8'h00, 16'h0000, 4'h0);
        write_reg(CFG_POINT_COUNT, 0);
        send_word(FUNC_LOAD_DIST, 8'h00, 8'h00, 16'h1234, 4'h0);
        write_reg(CFG_POINT_COUNT, 300);
        write_reg(CFG_CLUSTER_COUNT, 1);
        send_word(FUNC_RUN, 8'h00, 8'h00, 16'h0000, 4'h0);

        // Single point, and a full set of sixteen clusters.
        cluster_phase(1, 1, 200, 3);
        cluster_phase(16, 16, 1023, 20);

        // Random phases of small sizes; each phase is followed by up to ten noise words.
        while (words_sent < 1250) begin
            if (words_sent > 1050) quiet = 1'b1;
            n = $urandom_range(2, 10);
            k = $urandom_range(1, (n < 6) ? n : 6);
            case ($urandom_range(0, 3))
                0: lim = $urandom_range(0, 3);
                1: lim = 1023;
                default: lim = $urandom_range(4, 300);
            endcase
            cluster_phase(n, k, lim, $urandom_range(4, 16));
            repeat ($urandom_range(0, 10))
                send_word(kmc_func_t'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
                          16'($urandom), 4'($urandom));
        end

        // Large point count: loads may address the top row and column.
        write_reg(CFG_POINT_COUNT, 256);
        repeat (12)
            send_word(FUNC_LOAD_DIST, 8'($urandom), 8'($urandom), 16'($urandom), 4'($urandom));

        drain();
        repeat (50) @(negedge aclk);
        $display("Covered %0d words, %0d result words checked, %0d successful runs,",
                 words_sent, sb.checked, sb.runs_ok);
        $display("%0d good reads, error cases, zero and maximum pass limits, k from 1 to 16.",
                 sb.reads_ok);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+src
src/kmc_pkg.sv
src/kmc_ctrl.sv
src/kmc_datapath.sv
src/k_medoids_cluster_engine.sv
verif/k_medoids_cluster_engine_test.sv
